// ===== design/etq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the Euler-to-quaternion block.
package etq_pkg;

   localparam int SIN_STEPS = 5;
   localparam int COS_STEPS = 6;
   localparam int SC_LAT    = 21;   // sincos lane: x, 19 lane stages, output
   localparam int BACK_LAT  = SC_LAT + 4;

   localparam logic [30:0] Q30_ONE = 31'd1073741824;
   localparam logic [31:0] PI_Q30  = 32'd3373259426;
   localparam logic [63:0] RND30   = 64'd536870912;

   // Horner divisors, reciprocals floor(2^(32+L)/k) and their extra shifts L
   localparam logic [7:0]  SIN_K [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
   localparam logic [32:0] SIN_M [SIN_STEPS] = '{33'd4997780126, 33'd7635497415,
      33'd6544712070, 33'd6871947673, 33'd5726623061};
   localparam logic [3:0]  SIN_L [SIN_STEPS] = '{4'd7, 4'd7, 4'd6, 4'd5, 4'd3};

   localparam logic [7:0]  COS_K [COS_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [32:0] COS_M [COS_STEPS] = '{33'd8329633543, 33'd6108397932,
      33'd4908534052, 33'd4581298449, 33'd5726623061, 33'd4294967296};
   localparam logic [3:0]  COS_L [COS_STEPS] = '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd1};

   typedef struct packed {
      logic        neg;
      logic [31:0] mag;
   } angle_type;

   typedef struct packed {
      angle_type yaw;
      angle_type pitch;
      angle_type roll;
   } cls_type;

   typedef struct packed {
      logic        neg;
      logic [30:0] x;
      logic [31:0] u;
      logic [30:0] ts;
      logic [30:0] tc;
      logic [31:0] ps;
      logic [31:0] pc;
      logic [31:0] qs;
      logic [31:0] qc;
   } lane_type;

   typedef struct packed {
      logic        s_neg;
      logic [30:0] s_mag;
      logic [30:0] c_mag;
   } trig_type;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   function automatic logic [30:0] half_angle(input logic [31:0] m);
      logic [63:0] p;
      p = {32'd0, m} * {32'd0, PI_Q30} + 64'h8000_0000;
      return p[62:32];
   endfunction

   function automatic logic [31:0] sq30(input logic [30:0] x);
      logic [63:0] p;
      p = {33'd0, x} * {33'd0, x} + RND30;
      return p[61:30];
   endfunction

   function automatic logic [31:0] hs_prod(input logic [31:0] u, input logic [30:0] t);
      logic [63:0] p;
      p = {32'd0, u} * {33'd0, t};
      return p[61:30];
   endfunction

   // estimate of p/k, low by at most one
   function automatic logic [31:0] hs_recip(input logic [31:0] p, input logic [32:0] m,
                                            input logic [3:0] l);
      logic [64:0] r;
      r = {33'd0, p} * {32'd0, m};
      r = r >> (7'd32 + {3'd0, l});
      return r[31:0];
   endfunction

   function automatic logic [30:0] hs_fix(input logic [31:0] p, input logic [31:0] q0,
                                          input logic [7:0] k);
      logic [39:0] qk;
      logic [39:0] r;
      logic [31:0] q;
      qk = {8'd0, q0} * {32'd0, k};
      r  = {8'd0, p} - qk;
      q  = q0 + {31'd0, (r >= {32'd0, k})};
      if (q >= 32'd1073741824) return '0;
      else return Q30_ONE - q[30:0];
   endfunction

   function automatic logic [31:0] mul_a(input logic [30:0] a, input logic [30:0] b);
      logic [63:0] p;
      p = {33'd0, a} * {33'd0, b} + RND30;
      return p[61:30];
   endfunction

   function automatic logic [32:0] mul_b(input logic [31:0] a, input logic [30:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {33'd0, b} + RND30;
      return p[62:30];
   endfunction

   function automatic logic signed [33:0] to_s34(input logic neg, input logic [32:0] mag);
      logic signed [33:0] v;
      v = $signed({1'b0, mag});
      return neg ? -v : v;
   endfunction

   function automatic logic [15:0] to_q15(input logic signed [34:0] v);
      logic [34:0] mag;
      logic [35:0] m;
      logic [16:0] res;
      mag = v[34] ? 35'(-v) : 35'(v);
      m   = ({1'b0, mag} + 36'd16384) >> 15;
      if (v[34]) begin
         if (m > 36'd32768) m = 36'd32768;
         res = 17'h10000 - m[16:0];
      end else begin
         if (m > 36'd32767) m = 36'd32767;
         res = m[16:0];
      end
      return res[15:0];
   endfunction

endpackage

// ===== design/etq_fifo.sv =====
// Small synchronous word queue with occupancy count.
module etq_fifo import etq_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= wdata;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("push into full queue");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !empty) else $error("queue empty after push");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && !push && (cnt_ff == (AW+1)'(1)) |=> empty) else $error("queue not empty after last pop");

endmodule

// ===== design/etq_front.sv =====
// Front stage: takes an angle triple and splits each angle into sign and magnitude.
module etq_front import etq_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [ANGLE_BITS-1:0] yaw_angle,
   input  logic [ANGLE_BITS-1:0] pitch_angle,
   input  logic [ANGLE_BITS-1:0] roll_angle,
   output logic                  q_push,
   output cls_type               q_data,
   input  logic                  q_full
);

   logic    vld_ff, vld_in;
   cls_type data_ff;
   logic    accept;

   function automatic angle_type classify(input logic [ANGLE_BITS-1:0] ang);
      logic [31:0] a;
      angle_type   r;
      a     = 32'(ang) << (32 - ANGLE_BITS);
      r.neg = a[31];
      r.mag = a[31] ? (~a + 32'd1) : a;
      return r;
   endfunction

   assign full   = vld_ff && q_full;
   assign accept = push && !full;
   assign q_push = vld_ff && !q_full;
   assign q_data = data_ff;

   always_comb begin
      vld_in = vld_ff;
      if (accept) vld_in = 1'b1;
      else if (q_push) vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff.yaw   <= classify(yaw_angle);
         data_ff.pitch <= classify(pitch_angle);
         data_ff.roll  <= classify(roll_angle);
      end
   end

endmodule

// ===== design/etq_sincos.sv =====
// Pipelined half-angle sine and cosine lane (Horner series, reciprocal division).
module etq_sincos import etq_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  angle_type ang_i,
   output trig_type  trig_o
);

   localparam int LAST = 3 * COS_STEPS + 1;

   logic        neg0_ff;
   logic [30:0] x0_ff;
   lane_type    ln_ff [1:LAST];
   lane_type    init;
   trig_type    out_ff;
   logic [63:0] sprod;

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff <= ang_i.neg;
         x0_ff   <= half_angle(ang_i.mag);
      end
   end

   always_comb begin
      init     = '0;
      init.neg = neg0_ff;
      init.x   = x0_ff;
      init.u   = sq30(x0_ff);
      init.ts  = Q30_ONE;
      init.tc  = Q30_ONE;
   end

   always_ff @(posedge clock) begin
      if (en) ln_ff[1] <= init;
   end

   // each Horner step: product, reciprocal estimate, correction
   for (genvar j = 0; j < COS_STEPS; j++) begin : g_step
      localparam int JS = (j < SIN_STEPS) ? j : SIN_STEPS - 1;
      localparam bit SIN_ON = (j < SIN_STEPS);
      lane_type a_in, b_in, c_in;

      always_comb begin
         a_in    = ln_ff[3*j+1];
         a_in.ps = hs_prod(a_in.u, a_in.ts);
         a_in.pc = hs_prod(a_in.u, a_in.tc);
         b_in    = ln_ff[3*j+2];
         b_in.qs = hs_recip(b_in.ps, SIN_M[JS], SIN_L[JS]);
         b_in.qc = hs_recip(b_in.pc, COS_M[j], COS_L[j]);
         c_in    = ln_ff[3*j+3];
         if (SIN_ON) c_in.ts = hs_fix(c_in.ps, c_in.qs, SIN_K[JS]);
         c_in.tc = hs_fix(c_in.pc, c_in.qc, COS_K[j]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ln_ff[3*j+2] <= a_in;
            ln_ff[3*j+3] <= b_in;
            ln_ff[3*j+4] <= c_in;
         end
      end
   end

   assign sprod = {33'd0, ln_ff[LAST].x} * {33'd0, ln_ff[LAST].ts} + RND30;

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.s_neg <= ln_ff[LAST].neg;
         out_ff.s_mag <= sprod[60:30];
         out_ff.c_mag <= ln_ff[LAST].tc;
      end
   end

   assign trig_o = out_ff;

endmodule

// ===== design/etq_back.sv =====
// Back end: three sincos lanes, triple products, sums and Q1.15 rounding.
module etq_back import etq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     mid_empty,
   input  cls_type  mid_data,
   output logic     mid_pop,
   input  logic     out_full,
   output logic     out_push,
   output quat_type out_data
);

   logic                en;
   logic [BACK_LAT-1:0] vld_ff, vld_in;
   trig_type            ty, tp, tr;

   // first-level products and carried yaw terms
   logic [31:0] crcp_ff, srsp_ff, srcp_ff, crsp_ff;
   logic        srsp_n_ff, srcp_n_ff, crsp_n_ff;
   logic [30:0] cy_ff, sy_ff;
   logic        sy_n_ff;

   logic signed [33:0] t_ff [8];
   logic signed [34:0] w_ff, x_ff, y_ff, z_ff;
   quat_type           q_ff;

   assign en      = !out_full;
   assign mid_pop = en && !mid_empty;

   etq_sincos u_yaw   (.clock(clock), .en(en), .ang_i(mid_data.yaw),   .trig_o(ty));
   etq_sincos u_pitch (.clock(clock), .en(en), .ang_i(mid_data.pitch), .trig_o(tp));
   etq_sincos u_roll  (.clock(clock), .en(en), .ang_i(mid_data.roll),  .trig_o(tr));

   always_comb begin
      vld_in = {vld_ff[BACK_LAT-2:0], mid_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= vld_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crcp_ff   <= mul_a(tr.c_mag, tp.c_mag);
         srsp_ff   <= mul_a(tr.s_mag, tp.s_mag);
         srcp_ff   <= mul_a(tr.s_mag, tp.c_mag);
         crsp_ff   <= mul_a(tr.c_mag, tp.s_mag);
         srsp_n_ff <= tr.s_neg ^ tp.s_neg;
         srcp_n_ff <= tr.s_neg;
         crsp_n_ff <= tp.s_neg;
         cy_ff     <= ty.c_mag;
         sy_ff     <= ty.s_mag;
         sy_n_ff   <= ty.s_neg;

         t_ff[0] <= to_s34(1'b0,                mul_b(crcp_ff, cy_ff));
         t_ff[1] <= to_s34(srsp_n_ff ^ sy_n_ff, mul_b(srsp_ff, sy_ff));
         t_ff[2] <= to_s34(srcp_n_ff,           mul_b(srcp_ff, cy_ff));
         t_ff[3] <= to_s34(crsp_n_ff ^ sy_n_ff, mul_b(crsp_ff, sy_ff));
         t_ff[4] <= to_s34(crsp_n_ff,           mul_b(crsp_ff, cy_ff));
         t_ff[5] <= to_s34(srcp_n_ff ^ sy_n_ff, mul_b(srcp_ff, sy_ff));
         t_ff[6] <= to_s34(sy_n_ff,             mul_b(crcp_ff, sy_ff));
         t_ff[7] <= to_s34(srsp_n_ff,           mul_b(srsp_ff, cy_ff));

         w_ff <= 35'(t_ff[0]) + 35'(t_ff[1]);
         x_ff <= 35'(t_ff[2]) - 35'(t_ff[3]);
         y_ff <= 35'(t_ff[4]) + 35'(t_ff[5]);
         z_ff <= 35'(t_ff[6]) - 35'(t_ff[7]);

         q_ff.w <= to_q15(w_ff);
         q_ff.x <= to_q15(x_ff);
         q_ff.y <= to_q15(y_ff);
         q_ff.z <= to_q15(z_ff);
      end
   end

   assign out_push = en && vld_ff[BACK_LAT-1];
   assign out_data = q_ff;

endmodule

// ===== design/euler_to_quaternion_top.sv =====
// Euler angles (yaw, pitch, roll, ZYX order) to unit quaternion, Q1.15 output.
//
// Input channel: drive req_yaw_angle, req_pitch_angle, req_roll_angle and raise
// req_push; a word is taken at each clock edge with req_push high and req_full low.
// Angles are two's-complement binary angles, 2^(ANGLE_BITS-1) = pi.
// Result channel: while rsp_empty is low the oldest result sits on rsp_quat_w/x/y/z;
// it is taken at an edge with rsp_pop high.
// Throughput: one word per cycle, sustained while results are popped, with no dependence between words.
// Arithmetic pipeline: mostly the sincos lanes, 2 stages for half angle and square,
// 3 per Horner step over six cosine steps, one for the final sine product, then 4
// product/sum/round stages.
// A front register feeds a 4-word queue ahead of the arithmetic pipeline, and a
// 4-word result queue follows it.
// When the receiver stalls, the result queue fills, the arithmetic pipeline holds
// in place, then the middle queue fills and req_full rises; no word is dropped.
// Reset (synchronous, active high) empties both queues and all pipeline valids.
module euler_to_quaternion_top import etq_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [ANGLE_BITS-1:0] req_yaw_angle,
   input  logic [ANGLE_BITS-1:0] req_pitch_angle,
   input  logic [ANGLE_BITS-1:0] req_roll_angle,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic signed [15:0]    rsp_quat_w,
   output logic signed [15:0]    rsp_quat_x,
   output logic signed [15:0]    rsp_quat_y,
   output logic signed [15:0]    rsp_quat_z
);

   logic     mid_push, mid_full, mid_pop, mid_empty;
   cls_type  mid_wdata, mid_rdata;
   logic     out_push, out_full, out_pop;
   quat_type out_wdata, out_rdata;

   etq_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .push(req_push), .full(req_full),
      .yaw_angle(req_yaw_angle), .pitch_angle(req_pitch_angle),
      .roll_angle(req_roll_angle),
      .q_push(mid_push), .q_data(mid_wdata), .q_full(mid_full)
   );

   etq_fifo #(.WIDTH($bits(cls_type)), .DEPTH(4)) u_mid (
      .clock(clock), .reset(reset),
      .push(mid_push), .wdata(mid_wdata), .full(mid_full),
      .pop(mid_pop), .rdata(mid_rdata), .empty(mid_empty)
   );

   etq_back u_back (
      .clock(clock), .reset(reset),
      .mid_empty(mid_empty), .mid_data(mid_rdata), .mid_pop(mid_pop),
      .out_full(out_full), .out_push(out_push), .out_data(out_wdata)
   );

   assign out_pop = rsp_pop && !rsp_empty;

   etq_fifo #(.WIDTH($bits(quat_type)), .DEPTH(4)) u_out (
      .clock(clock), .reset(reset),
      .push(out_push), .wdata(out_wdata), .full(out_full),
      .pop(out_pop), .rdata(out_rdata), .empty(rsp_empty)
   );

   assign rsp_quat_w = out_rdata.w;
   assign rsp_quat_x = out_rdata.x;
   assign rsp_quat_y = out_rdata.y;
   assign rsp_quat_z = out_rdata.z;

endmodule

// ===== tb/sv/euler_to_quaternion_checker.sv =====
// Checker: watches both channels, predicts quaternions and compares them.
module euler_to_quaternion_checker #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic [ANGLE_BITS-1:0] req_yaw_angle,
   input  logic [ANGLE_BITS-1:0] req_pitch_angle,
   input  logic [ANGLE_BITS-1:0] req_roll_angle,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic signed [15:0]    rsp_quat_w,
   input  logic signed [15:0]    rsp_quat_x,
   input  logic signed [15:0]    rsp_quat_y,
   input  logic signed [15:0]    rsp_quat_z,
   output int                    fail_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] w;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } quat_type;

   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam longint unsigned PI_HALF = 64'd3373259426;

   quat_type expected_quats[$];

   function automatic longint unsigned taylor_step(longint unsigned t, longint unsigned u,
                                                   longint unsigned k);
      longint unsigned p;
      p = ((u * t) >> 30) / k;
      return (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
   endfunction

   // signed Q30 sine and cosine of half the binary angle
   function automatic void half_trig(input logic [ANGLE_BITS-1:0] ang, output longint s,
                                     output longint c);
      logic [31:0] a;
      logic neg;
      longint unsigned m, x, u, t, sm;
      a = 32'(ang) << (32 - ANGLE_BITS);
      neg = a[31];
      m = neg ? (64'h1_0000_0000 - 64'(a)) : 64'(a);
      x = (m * PI_HALF + 64'h8000_0000) >> 32;
      u = (x * x + (64'd1 << 29)) >> 30;
      t = taylor_step(ONE_Q30, u, 110);
      t = taylor_step(t, u, 72);
      t = taylor_step(t, u, 42);
      t = taylor_step(t, u, 20);
      t = taylor_step(t, u, 6);
      sm = (x * t + (64'd1 << 29)) >> 30;
      s = neg ? -longint'(sm) : longint'(sm);
      t = taylor_step(ONE_Q30, u, 132);
      t = taylor_step(t, u, 90);
      t = taylor_step(t, u, 56);
      t = taylor_step(t, u, 30);
      t = taylor_step(t, u, 12);
      t = taylor_step(t, u, 2);
      c = longint'(t);
   endfunction

   function automatic longint unsigned abs_val(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      longint unsigned m;
      m = (abs_val(a) * abs_val(b) + (64'd1 << 29)) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [15:0] round_q15(longint v);
      longint unsigned m;
      m = (abs_val(v) + (64'd1 << 14)) >> 15;
      if (v < 0) begin
         if (m > 32768) m = 32768;
         return 16'((64'h10000 - m) & 64'hFFFF);
      end
      if (m > 32767) m = 32767;
      return 16'(m);
   endfunction

   function automatic quat_type zyx_quat(logic [ANGLE_BITS-1:0] yaw,
                                         logic [ANGLE_BITS-1:0] pitch,
                                         logic [ANGLE_BITS-1:0] roll);
      longint sy, cy, sp, cp, sr, cr, crcp, srsp, srcp, crsp;
      quat_type q;
      half_trig(yaw, sy, cy);
      half_trig(pitch, sp, cp);
      half_trig(roll, sr, cr);
      crcp = mul_q30(cr, cp);
      srsp = mul_q30(sr, sp);
      srcp = mul_q30(sr, cp);
      crsp = mul_q30(cr, sp);
      q.w = round_q15(mul_q30(crcp, cy) + mul_q30(srsp, sy));
      q.x = round_q15(mul_q30(srcp, cy) - mul_q30(crsp, sy));
      q.y = round_q15(mul_q30(crsp, cy) + mul_q30(srcp, sy));
      q.z = round_q15(mul_q30(crcp, sy) - mul_q30(srsp, cy));
      return q;
   endfunction

   assign pending_count = expected_quats.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      quat_type exp_q, got;
      if (!reset) begin
         if (req_push && !req_full)
            expected_quats.push_back(zyx_quat(req_yaw_angle, req_pitch_angle,
                                              req_roll_angle));
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z};
            if (expected_quats.size() == 0) begin
               $display("%0t: unexpected word w=%0d x=%0d y=%0d z=%0d", $time,
                        got.w, got.x, got.y, got.z);
               fail_count <= fail_count + 1;
            end else begin
               exp_q = expected_quats.pop_front();
               if (got !== exp_q) begin
                  $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d", $time,
                           exp_q.w, exp_q.x, exp_q.y, exp_q.z);
                  $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d", $time,
                           got.w, got.x, got.y, got.z);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ===== tb/sv/euler_to_quaternion_top_tb.sv =====
// Testbench top: clock, reset, angle stimulus, result draining and verdict.
module euler_to_quaternion_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_BITS = 16;
   localparam int RANDOM_WORDS = 700;
   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [ANGLE_BITS-1:0] req_yaw_angle = '0;
   logic [ANGLE_BITS-1:0] req_pitch_angle = '0;
   logic [ANGLE_BITS-1:0] req_roll_angle = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   int fail_count, pending_count;
   int cycle_count = 0;
   bit stim_done = 1'b0;

   always #6 clock = ~clock;

   euler_to_quaternion_top #(.ANGLE_BITS(ANGLE_BITS)) uut (.*);

   euler_to_quaternion_checker #(.ANGLE_BITS(ANGLE_BITS)) checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // pick angles: edges of the circle, points near a quarter turn either way, or anything
   function automatic logic [ANGLE_BITS-1:0] pick_angle();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(16'h4000 + $urandom_range(0, 4) - 2);
         4: return 16'(16'hC000 + $urandom_range(0, 4) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_word(input logic [ANGLE_BITS-1:0] yaw,
                            input logic [ANGLE_BITS-1:0] pitch,
                            input logic [ANGLE_BITS-1:0] roll, input int gap);
      repeat (gap) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_yaw_angle <= yaw;
      req_pitch_angle <= pitch;
      req_roll_angle <= roll;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   function automatic int draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, 15);
   endfunction

   logic [ANGLE_BITS-1:0] corner [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001,
                                         16'hFFFF, 16'h4000};

   initial begin
      bit burst;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 6; i++)
         send_word(corner[i], corner[(i + 2) % 6], corner[(i + 4) % 6], 0);
      send_word(16'h8000, 16'h8000, 16'h8000, 1);
      send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
      send_word(16'h0000, 16'h8000, 16'h0000, 3);
      send_word(16'h0000, 16'h0000, 16'h8000, 0);
      send_word(16'h8000, 16'h0000, 16'h0000, 0);
      send_word(16'h5555, 16'hAAAA, 16'h5555, 2);
      send_word(16'hAAAA, 16'h5555, 16'hAAAA, 0);
      send_word(16'h4000, 16'hC000, 16'h2000, 0);
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 100 == 0) burst = $urandom_range(0, 1);
         send_word(pick_angle(), pick_angle(), pick_angle(), draw_gap(burst));
      end
      req_push <= 1'b0;
      stim_done = 1'b1;
   end

   initial begin
      bit burst;
      @(negedge reset);
      forever begin
         if ($urandom_range(0, 63) == 0) burst = $urandom_range(0, 1);
         repeat (draw_gap(burst)) begin
            rsp_pop <= 1'b0;
            @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   initial begin
      wait (stim_done);
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule

// ===== files.f =====
design/etq_pkg.sv
design/etq_fifo.sv
design/etq_front.sv
design/etq_sincos.sv
design/etq_back.sv
design/euler_to_quaternion_top.sv
tb/sv/euler_to_quaternion_checker.sv
tb/sv/euler_to_quaternion_top_tb.sv
